@@ rtl/core/swc_pkg.sv @@
// swc_pkg: shared types and constants for the sliding window covariance block
// no dependencies; used by swc_ctrl, swc_datapath and sliding_window_covariance
`default_nettype none

package swc_pkg;

    localparam int CFG_BITS = 8;
    localparam int WINDOW_RESET = 100;
    localparam int VALUE_BITS = 40;
    localparam int IDX_BITS = 2;
    localparam int DIMENSION = 3;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // take a new sample beat, update slot and count
        logic old_rd;    // read the old entry from window memory
        logic upd;       // update sums with sample minus old
        logic prod_step; // one product update step
        logic ent_start; // start the numerator of one entry
        logic num_step;  // numerator step
        logic div_start; // start the divider
        logic restart;   // clear sums and count
    } swc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic valid_n;   // at least two samples
    } swc_stat_t;

endpackage : swc_pkg

`default_nettype wire

@@ rtl/core/sliding_window_covariance.sv @@
// sliding window 3x3 covariance matrix over a ring of samples, nine beats per item
// steps: load, old read, sum update, product steps, then per entry numerator, divide, output beat
// NUM_BITS = 2*SAMPLE_BITS + 2*clog2(WINDOW_MAX+1) + 3 + FRACTION_BITS, 59 at the defaults
// pacing: a new item is taken only after the last beat of the previous one is captured, set by the
// shared bit-serial divider; output stalls longer than one entry's compute add to it
// reset: async active low; window length 100, window empty, sums zero; window memory not cleared
// writing window_length restarts the window on the same edge
// depends on swc_pkg, swc_ctrl, swc_datapath, swc_div
`default_nettype none

module sliding_window_covariance #(
    parameter int WINDOW_MAX = 128,
    parameter int SAMPLE_BITS = 16,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [swc_pkg::CFG_BITS-1:0]      cfg_wdata,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [SAMPLE_BITS-1:0]            sample_x,
    input  wire logic [SAMPLE_BITS-1:0]            sample_y,
    input  wire logic [SAMPLE_BITS-1:0]            sample_z,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [swc_pkg::IDX_BITS-1:0]           row_index,
    output logic [swc_pkg::IDX_BITS-1:0]           col_index,
    output logic [swc_pkg::VALUE_BITS-1:0]         cov_value,
    output logic [swc_pkg::CFG_BITS-1:0]           samples_used,
    output logic                                   cov_valid,
    output logic                                   is_last
);

    swc_pkg::swc_cmd_t  cmd;
    swc_pkg::swc_stat_t stat;
    logic [swc_pkg::CFG_BITS-1:0]   len_reg;
    logic [swc_pkg::CFG_BITS-1:0]   len_clip;
    logic [swc_pkg::IDX_BITS-1:0]   ent_a, ent_b;
    logic [1:0]                     step;
    logic                           cap, last;
    logic [swc_pkg::VALUE_BITS-1:0] value;
    logic [swc_pkg::CFG_BITS-1:0]   count;

    // window length clipped into its legal range
    always_comb
    begin
        if (cfg_wdata < swc_pkg::CFG_BITS'(2))
            len_clip = swc_pkg::CFG_BITS'(2);
        else if (cfg_wdata > swc_pkg::CFG_BITS'(WINDOW_MAX))
            len_clip = swc_pkg::CFG_BITS'(WINDOW_MAX);
        else
            len_clip = cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= swc_pkg::CFG_BITS'(swc_pkg::WINDOW_RESET);
        else if (cfg_we)
            len_reg <= len_clip;
    end

    swc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .cfg_we    (cfg_we),
        .stat      (stat),
        .cmd       (cmd),
        .ent_a     (ent_a),
        .ent_b     (ent_b),
        .step      (step),
        .cap       (cap),
        .last      (last)
    );

    swc_datapath #(
        .WINDOW_MAX    (WINDOW_MAX),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .win_len  (cmd.restart ? len_clip : len_reg),
        .sample_x (sample_x),
        .sample_y (sample_y),
        .sample_z (sample_z),
        .ent_a    (ent_a),
        .ent_b    (ent_b),
        .step     (step),
        .value    (value),
        .count    (count)
    );

    // output beat register
    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            row_index    <= ent_a;
            col_index    <= ent_b;
            cov_value    <= stat.valid_n ? value : '0;
            samples_used <= count;
            cov_valid    <= stat.valid_n;
            is_last      <= last;
        end
    end

endmodule : sliding_window_covariance

`default_nettype wire

@@ rtl/core/swc_div.sv @@
// swc_div: restoring divider, one quotient bit per cycle, signed truncation
// depends on nothing; instantiated by swc_datapath
`default_nettype none

module swc_div #(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 24
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [NUM_BITS-1:0] num,
    input  wire logic        [DEN_BITS-1:0] den,
    output logic signed      [NUM_BITS-1:0] quot,
    output logic                            done
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0]  q_reg, q_next;
    logic [DEN_BITS:0]    r_reg, r_next;
    logic [DEN_BITS-1:0]  d_reg, d_next;
    logic                 neg_reg, neg_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DEN_BITS+1:0]  trial;
    logic [NUM_BITS-1:0]  mag;

    // magnitude of the numerator
    assign mag = num[NUM_BITS-1] ? (~num + NUM_BITS'(1)) : num;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[NUM_BITS-1]} - {2'b00, d_reg};
        if (start)
        begin
            q_next    = mag;
            r_next    = '0;
            d_next    = den;
            neg_next  = num[NUM_BITS-1];
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            if (!trial[DEN_BITS+1])
            begin
                r_next = trial[DEN_BITS:0];
                q_next = {q_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
                q_next = {q_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign quot = neg_reg ? (~q_reg + NUM_BITS'(1)) : q_reg;
    assign done = done_reg;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("divider done without busy");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("divider did not start");
`endif

endmodule : swc_div

`default_nettype wire

@@ rtl/core/swc_datapath.sv @@
// swc_datapath: window memory, running sums, shared multiplier and divider
// depends on swc_pkg and swc_div; instantiated by sliding_window_covariance
`default_nettype none

module swc_datapath #(
    parameter int WINDOW_MAX = 128,
    parameter int SAMPLE_BITS = 16,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire swc_pkg::swc_cmd_t        cmd,
    output swc_pkg::swc_stat_t            stat,
    input  wire logic [swc_pkg::CFG_BITS-1:0] win_len,
    input  wire logic [SAMPLE_BITS-1:0]   sample_x,
    input  wire logic [SAMPLE_BITS-1:0]   sample_y,
    input  wire logic [SAMPLE_BITS-1:0]   sample_z,
    input  wire logic [swc_pkg::IDX_BITS-1:0] ent_a,
    input  wire logic [swc_pkg::IDX_BITS-1:0] ent_b,
    input  wire logic [1:0]               step,
    output logic [swc_pkg::VALUE_BITS-1:0] value,
    output logic [swc_pkg::CFG_BITS-1:0]  count
);

    localparam int SLOT_BITS = $clog2(WINDOW_MAX);
    localparam int CNT_BITS  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS + 1;
    localparam int PS_BITS   = 2 * SAMPLE_BITS + CNT_BITS + 1;
    localparam int NUM_BITS  = PS_BITS + CNT_BITS + 2 + FRACTION_BITS;
    localparam int DEN_BITS  = 2 * CNT_BITS;
    localparam int VB        = swc_pkg::VALUE_BITS;
    localparam int NPAIR     = 6;
    localparam int PB        = 2 * SAMPLE_BITS + 2;
    localparam longint VMAX_L = (longint'(1) <<< (VB - 1)) - longint'(1);
    localparam longint VMIN_L = -VMAX_L - longint'(1);

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;

    smp_t mem_x [WINDOW_MAX];
    smp_t mem_y [WINDOW_MAX];
    smp_t mem_z [WINDOW_MAX];

    smp_t                        s_reg   [3];
    smp_t                        o_reg   [3];
    logic [SLOT_BITS-1:0]        slot_reg;
    logic [CNT_BITS-1:0]         cnt_reg;
    logic                        full_reg;
    logic signed [SUM_BITS-1:0]  csum_reg [3];
    logic signed [PS_BITS-1:0]   psum_reg [NPAIR];
    logic [2:0]                  pidx_reg;
    logic signed [NUM_BITS-1:0]  acc_reg;
    logic signed [NUM_BITS-1:0]  num_q;
    logic [DEN_BITS-1:0]         den_reg;
    logic                        div_done;
    logic [SLOT_BITS:0]          slot_inc;
    logic [1:0]                  pa, pb;
    logic signed [PB-1:0]        prod;
    logic signed [PS_BITS-1:0]   ps_sel;
    logic [2:0]                  pe;
    logic signed [NUM_BITS-1:0]  mterm;
    logic signed [VB-1:0]        sat;

    // next ring slot wraps at the window length
    assign slot_inc = {1'b0, slot_reg} + (SLOT_BITS+1)'(1);

    // pair table for product sum updates: 00 01 02 11 12 22
    always_comb
    begin
        case (pidx_reg)
            3'd0:    begin pa = 2'd0; pb = 2'd0; end
            3'd1:    begin pa = 2'd0; pb = 2'd1; end
            3'd2:    begin pa = 2'd0; pb = 2'd2; end
            3'd3:    begin pa = 2'd1; pb = 2'd1; end
            3'd4:    begin pa = 2'd1; pb = 2'd2; end
            default: begin pa = 2'd2; pb = 2'd2; end
        endcase
    end

    // pair index of the entry being computed
    always_comb
    begin
        logic [1:0] lo, hi;
        lo = (ent_a < ent_b) ? ent_a : ent_b;
        hi = (ent_a < ent_b) ? ent_b : ent_a;
        case (lo)
            2'd0:    pe = 3'(hi);
            2'd1:    pe = 3'd2 + 3'(hi);
            default: pe = 3'd5;
        endcase
    end

    // shared multiplier: sample product minus old product in product steps
    always_comb
    begin
        logic signed [2*SAMPLE_BITS-1:0] p1, p0;
        p1 = s_reg[pa] * s_reg[pb];
        p0 = o_reg[pa] * o_reg[pb];
        prod = PB'(p1) - PB'(p0);
    end

    assign ps_sel = psum_reg[pe];

    // numerator term: step 0 n*Sab, step 1 Sa*Sb
    always_comb
    begin
        if (step == 2'd0)
            mterm = NUM_BITS'($signed({1'b0, cnt_reg})) * NUM_BITS'(ps_sel);
        else
            mterm = NUM_BITS'(csum_reg[ent_a < ent_b ? ent_a : ent_b])
                  * NUM_BITS'(csum_reg[ent_a < ent_b ? ent_b : ent_a]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= SLOT_BITS'(swc_pkg::WINDOW_RESET - 1);
            cnt_reg  <= '0;
            full_reg <= 1'b0;
            pidx_reg <= '0;
            for (int i = 0; i < 3; i++)
                csum_reg[i] <= '0;
            for (int i = 0; i < NPAIR; i++)
                psum_reg[i] <= '0;
        end
        else if (cmd.restart)
        begin
            slot_reg <= SLOT_BITS'(win_len - swc_pkg::CFG_BITS'(1));
            cnt_reg  <= '0;
            full_reg <= 1'b0;
            pidx_reg <= '0;
            for (int i = 0; i < 3; i++)
                csum_reg[i] <= '0;
            for (int i = 0; i < NPAIR; i++)
                psum_reg[i] <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                slot_reg <= (slot_inc >= (SLOT_BITS+1)'(win_len)) ?
                            '0 : slot_inc[SLOT_BITS-1:0];
                full_reg <= (swc_pkg::CFG_BITS'(cnt_reg) >= win_len);
                if (swc_pkg::CFG_BITS'(cnt_reg) < win_len)
                    cnt_reg <= cnt_reg + CNT_BITS'(1);
                pidx_reg <= '0;
            end
            if (cmd.upd)
            begin
                for (int i = 0; i < 3; i++)
                    csum_reg[i] <= csum_reg[i] + SUM_BITS'(s_reg[i]) - SUM_BITS'(o_reg[i]);
            end
            if (cmd.prod_step)
            begin
                psum_reg[pidx_reg] <= psum_reg[pidx_reg] + PS_BITS'(prod);
                pidx_reg <= pidx_reg + 3'd1;
            end
        end
    end

    // sample capture, old entry read and memory write
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_reg[0] <= sample_x;
            s_reg[1] <= (swc_pkg::DIMENSION > 1) ? sample_y : '0;
            s_reg[2] <= (swc_pkg::DIMENSION > 2) ? sample_z : '0;
        end
        if (cmd.old_rd)
        begin
            o_reg[0] <= full_reg ? mem_x[slot_reg] : '0;
            o_reg[1] <= full_reg ? mem_y[slot_reg] : '0;
            o_reg[2] <= full_reg ? mem_z[slot_reg] : '0;
        end
        if (cmd.upd)
        begin
            mem_x[slot_reg] <= s_reg[0];
            mem_y[slot_reg] <= s_reg[1];
            mem_z[slot_reg] <= s_reg[2];
        end
        if (cmd.ent_start)
        begin
            acc_reg <= mterm;
            den_reg <= DEN_BITS'(cnt_reg) * DEN_BITS'(cnt_reg - CNT_BITS'(1));
        end
        if (cmd.num_step)
            acc_reg <= (acc_reg - mterm) <<< FRACTION_BITS;
    end

    swc_div #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (acc_reg),
        .den   (den_reg),
        .quot  (num_q),
        .done  (div_done)
    );

    // saturate to the value range
    always_comb
    begin
        if (num_q > NUM_BITS'(VMAX_L))
            sat = {1'b0, {(VB-1){1'b1}}};
        else if (num_q < NUM_BITS'(VMIN_L))
            sat = {1'b1, {(VB-1){1'b0}}};
        else
            sat = VB'(num_q);
    end

    assign value         = sat;
    assign count         = swc_pkg::CFG_BITS'(cnt_reg);
    assign stat.div_done = div_done;
    assign stat.valid_n  = (cnt_reg >= CNT_BITS'(2));

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.restart || swc_pkg::CFG_BITS'(cnt_reg) <= win_len)
        else $error("fill count above window length");
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (slot_reg < SLOT_BITS'(WINDOW_MAX - 1)
                      || slot_reg == SLOT_BITS'(WINDOW_MAX - 1)))
        else $error("slot out of range");
    a_pidx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.prod_step |-> pidx_reg < 3'd6) else $error("pair index overrun");
`endif

endmodule : swc_datapath

`default_nettype wire

@@ rtl/core/swc_ctrl.sv @@
// swc_ctrl: sequencer for update, per entry numerator, divide and output beat
// depends on swc_pkg; instantiated by sliding_window_covariance
`default_nettype none

module swc_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     out_stall,
    output logic                          out_valid,
    input  wire logic                     cfg_we,
    input  wire swc_pkg::swc_stat_t       stat,
    output swc_pkg::swc_cmd_t             cmd,
    output logic [swc_pkg::IDX_BITS-1:0]  ent_a,
    output logic [swc_pkg::IDX_BITS-1:0]  ent_b,
    output logic [1:0]                    step,
    output logic                          cap,
    output logic                          last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_PROD = 3'd3;
    localparam logic [2:0] S_NUM  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] pcnt_reg, pcnt_next;
    logic [1:0] a_reg, a_next, b_reg, b_next;
    logic       ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        pcnt_next  = pcnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        step       = 2'd0;
        cap        = 1'b0;
        cmd.restart = cfg_we;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !cfg_we)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.old_rd = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                pcnt_next  = '0;
                state_next = S_PROD;
            end
            S_PROD:
            begin
                cmd.prod_step = 1'b1;
                pcnt_next = pcnt_reg + 3'd1;
                if (pcnt_reg == 3'd5)
                begin
                    a_next     = '0;
                    b_next     = '0;
                    pcnt_next  = '0;
                    state_next = S_NUM;
                end
            end
            S_NUM:
            begin
                // load n*Sab, then subtract Sa*Sb and scale
                if (pcnt_reg == 3'd0)
                begin
                    cmd.ent_start = 1'b1;
                    step = 2'd0;
                    pcnt_next = 3'd1;
                end
                else
                begin
                    cmd.num_step = 1'b1;
                    step = 2'd1;
                    state_next = S_DIV;
                    pcnt_next = 3'd2;
                end
            end
            S_DIV:
            begin
                if (pcnt_reg == 3'd2)
                begin
                    cmd.div_start = 1'b1;
                    pcnt_next = 3'd3;
                end
                else if (stat.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait until the output register is free
                if (!ov_next)
                begin
                    cap     = 1'b1;
                    ov_next = 1'b1;
                    if (b_reg == 2'd2)
                    begin
                        b_next = '0;
                        a_next = a_reg + 2'd1;
                    end
                    else
                        b_next = b_reg + 2'd1;
                    pcnt_next = '0;
                    if (a_reg == 2'd2 && b_reg == 2'd2)
                        state_next = S_IDLE;
                    else
                        state_next = S_NUM;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pcnt_reg  <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pcnt_reg  <= pcnt_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || cfg_we;
    assign out_valid = ov_reg;
    assign ent_a     = a_reg;
    assign ent_b     = b_reg;
    assign last      = (a_reg == 2'd2) && (b_reg == 2'd2);

`ifndef NO_ASSERTIONS
    a_cap_free: assert property (@(posedge clk) disable iff (!rst_n)
        cap |-> (!ov_reg || !out_stall)) else $error("output beat overwritten");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE) else $error("load outside idle");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == S_DIV) else $error("divide left early");
`endif

endmodule : swc_ctrl

`default_nettype wire
